// File: src/tdp_pkg.sv
// ----------------------------------------------------------------------------
// Tag dedup table package
// Shared types, codes and sizes for the tag deduplication table.
// ----------------------------------------------------------------------------
`default_nettype none

package tdp_pkg;

  // Default number of table slots.
  localparam int TABLE_SLOTS_DEF = 16;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Packed stream widths, whole bytes.
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 112;

  // Result kinds.
  localparam logic RK_OBSERVE = 1'b0;
  localparam logic RK_DUMP    = 1'b1;

  // Observe status codes.
  localparam logic [1:0] ST_MATCH  = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_DROP   = 2'd2;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic        is_dump;
    logic [31:0] id_high;
    logic [63:0] id_low;
    logic [7:0]  rssi;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [3:0]  index;
    logic        valid;
    logic [31:0] id_high;
    logic [63:0] id_low;
    logic [7:0]  rssi;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// File: src/tdp_front.sv
// ----------------------------------------------------------------------------
// Tag dedup front end
// Accepts stream transfers, classifies them as observe or dump requests and
// holds them in a short queue for the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_front (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [tdp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  wire                              s_axis_tuser,
  output logic                             q_valid,
  input  wire                              q_ready,
  output tdp_pkg::item_t                   q_item
);
  import tdp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;
  item_t              in_item;

  // Classify the incoming transfer.
  always_comb begin
    in_item.is_dump = s_axis_tuser;
    in_item.id_high = s_axis_tdata[31:0];
    in_item.id_low  = s_axis_tdata[95:32];
    in_item.rssi    = s_axis_tdata[103:96];
  end

  assign s_axis_tready = (count != CNT_W'(QUEUE_DEPTH));
  assign q_valid       = (count != '0);
  assign q_item        = mem[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_valid && q_ready;

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // A push into a full queue never happens.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(QUEUE_DEPTH)) && !pop |=> count == CNT_W'(QUEUE_DEPTH))
    else $error("queue count changed while full and not popped");

endmodule

`default_nettype wire

// File: src/tdp_back.sv
// ----------------------------------------------------------------------------
// Tag dedup table engine
// Holds the tag table, matches observes against all slots in parallel,
// keeps the peak RSSI, inserts new tags and dumps the table.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_back #(
  parameter int TABLE_SLOTS = tdp_pkg::TABLE_SLOTS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  output logic                q_ready,
  input  tdp_pkg::item_t      q_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output tdp_pkg::res_t       out_res
);
  import tdp_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  // Table contents; only the valid bits are reset.
  logic [TABLE_SLOTS-1:0]  slot_valid;
  logic [31:0]             slot_idh  [TABLE_SLOTS];
  logic [63:0]             slot_idl  [TABLE_SLOTS];
  logic signed [7:0]       slot_rssi [TABLE_SLOTS];

  logic [1:0]              state;
  logic [SLOT_W-1:0]       dump_cnt;

  // Work registers for the observe in flight.
  logic [31:0]             w_idh;
  logic [63:0]             w_idl;
  logic signed [7:0]       w_rssi;
  logic [TABLE_SLOTS-1:0]  match_vec;
  logic [TABLE_SLOTS-1:0]  free_vec;

  logic [TABLE_SLOTS-1:0]  match_comb;
  logic [SLOT_W-1:0]       match_idx;
  logic [SLOT_W-1:0]       free_idx;
  logic                    out_free;
  logic                    out_load;
  logic                    dump_last;
  logic                    any_match;
  logic                    any_free;
  res_t                    upd_res;
  res_t                    dump_res;

  assign q_ready   = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = ((state == S_UPD) || (state == S_DUMP)) && out_free;
  assign dump_last = (dump_cnt == SLOT_W'(TABLE_SLOTS - 1));
  assign any_match = |match_vec;
  assign any_free  = |free_vec;

  // Parallel compare of the queue head against every valid slot.
  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      match_comb[i] = slot_valid[i] && (slot_idh[i] == q_item.id_high) &&
                      (slot_idl[i] == q_item.id_low);
    end
  end

  // Lowest-numbered matching and free slots.
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_idx = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Observe result.
  always_comb begin
    upd_res         = '0;
    upd_res.kind    = RK_OBSERVE;
    upd_res.last    = 1'b1;
    if (any_match) begin
      upd_res.status = ST_MATCH;
      upd_res.index  = 4'(match_idx);
    end else if (any_free) begin
      upd_res.status = ST_INSERT;
      upd_res.index  = 4'(free_idx);
    end else begin
      upd_res.status = ST_DROP;
    end
  end

  // Dump result for the current slot; free slots read as zero.
  always_comb begin
    dump_res        = '0;
    dump_res.kind   = RK_DUMP;
    dump_res.status = ST_MATCH;
    dump_res.index  = 4'(dump_cnt);
    dump_res.valid  = slot_valid[dump_cnt];
    dump_res.last   = dump_last;
    if (slot_valid[dump_cnt]) begin
      dump_res.id_high = slot_idh[dump_cnt];
      dump_res.id_low  = slot_idl[dump_cnt];
      dump_res.rssi    = slot_rssi[dump_cnt];
    end
  end

  // Control: sequencer, valid bits, dump counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      dump_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      // The output register holds its result until taken, then reloads when free.
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            dump_cnt <= '0;
            state    <= q_item.is_dump ? S_DUMP : S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            if (!any_match && any_free) begin
              slot_valid[free_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            if (dump_last) begin
              slot_valid <= '0;
              state      <= S_IDLE;
            end else begin
              dump_cnt <= dump_cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: work registers, table entries and the output register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      w_idh     <= q_item.id_high;
      w_idl     <= q_item.id_low;
      w_rssi    <= q_item.rssi;
      match_vec <= match_comb;
      free_vec  <= ~slot_valid;
    end
    if (state == S_UPD && out_free) begin
      out_res <= upd_res;
      if (any_match) begin
        if (w_rssi > slot_rssi[match_idx]) begin
          slot_rssi[match_idx] <= w_rssi;
        end
      end else if (any_free) begin
        slot_idh[free_idx]  <= w_idh;
        slot_idl[free_idx]  <= w_idl;
        slot_rssi[free_idx] <= w_rssi;
      end
    end
    if (state == S_DUMP && out_free) begin
      out_res <= dump_res;
    end
  end

  // A tag is never held in two valid slots at once.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> $onehot0(match_vec))
    else $error("observe matched more than one slot");

  // An insert adds exactly one valid slot.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && out_free && !any_match && any_free |=>
      $countones(slot_valid) == $past($countones(slot_valid)) + 1)
    else $error("insert did not add exactly one slot");

  // The final dump result leaves the table empty.
  a_dump_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP && out_free && dump_last |=> slot_valid == '0)
    else $error("table not cleared after dump");

endmodule

`default_nettype wire

// File: src/tag_dedup_peak_rssi_table_top.sv
// ----------------------------------------------------------------------------
// Tag dedup table with peak RSSI
// Top level: stream ports, request queue and table engine.
// ----------------------------------------------------------------------------
// An observe request (tuser 0) looks up its 96-bit EPC in all TABLE_SLOTS
// slots at once and returns one result: matched (the slot keeps the larger
// RSSI), inserted into the lowest free slot, or dropped when the table is
// full. A dump request (tuser 1) returns one result per slot in index order,
// tlast on the final one, and then empties the table. Requests wait in a
// two-entry queue; the table engine takes an observe from the queue head,
// registers the parallel compare in its work registers, then updates the
// slot and loads the result into the single output register. A dump sends
// one slot per cycle through that output register while the result side
// is ready; backpressure on the result side holds the engine in place.
`default_nettype none

module tag_dedup_peak_rssi_table_top #(
  parameter int TABLE_SLOTS = tdp_pkg::TABLE_SLOTS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] tag_id_high, [95:32] tag_id_low, [103:96] tag_rssi
  input  wire  [tdp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] req_type
  input  wire                              s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [1:0] observe_status, [5:2] slot_index, [6] entry_valid,
  // [38:7] entry_id_high, [102:39] entry_id_low, [110:103] entry_rssi,
  // [111] zero
  output logic [tdp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] result_kind
  output logic                             m_axis_tuser,
  // last_of_run
  output logic                             m_axis_tlast
);
  import tdp_pkg::*;

  logic   q_valid;
  logic   q_ready;
  item_t  q_item;
  res_t   res;

  tdp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  tdp_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Pack the result onto the master side.
  assign m_axis_tdata = {1'b0, res.rssi, res.id_low, res.id_high, res.valid,
                         res.index, res.status};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
